[design/utf8dv_pkg.sv]
// ----------------------------------------------------------------------------
// utf8dv_pkg
// Types and constants shared by the UTF-8 decode and validate unit.
// ----------------------------------------------------------------------------
package utf8dv_pkg;

	localparam int unsigned TOTAL_WIDTH = 32;
	localparam int unsigned CP_WIDTH    = 21;

	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] MASK_LEAD2  = 8'hE0;
	localparam logic [7:0] CODE_LEAD2  = 8'hC0;
	localparam logic [7:0] MASK_LEAD3  = 8'hF0;
	localparam logic [7:0] CODE_LEAD3  = 8'hE0;
	localparam logic [7:0] MASK_LEAD4  = 8'hF8;
	localparam logic [7:0] CODE_LEAD4  = 8'hF0;
	localparam logic [7:0] MASK_CONT   = 8'hC0;
	localparam logic [7:0] CODE_CONT   = 8'h80;
	localparam logic [7:0] BITS_LEAD2  = 8'h1F;
	localparam logic [7:0] BITS_LEAD3  = 8'h0F;
	localparam logic [7:0] BITS_LEAD4  = 8'h07;
	localparam logic [7:0] BITS_CONT   = 8'h3F;

	localparam logic KIND_POINT   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_string;
	} item_t;

	typedef struct packed {
		logic                   kind;
		logic [CP_WIDTH-1:0]    code_point;
		logic                   broken;
		logic [TOTAL_WIDTH-1:0] point_total;
		logic                   all_valid;
		logic                   last_result;
	} result_t;

	// output of the shared byte unit
	typedef struct packed {
		logic                bad;
		logic [2:0]          len;
		logic [CP_WIDTH-1:0] cp;
	} step_res_t;

endpackage

[design/utf8dv_step.sv]
// ----------------------------------------------------------------------------
// utf8dv_step
// Shared byte unit: classifies a lead byte (length and payload bits) or
// checks a continuation byte and shifts its six bits into the code point.
// ----------------------------------------------------------------------------
module utf8dv_step
	import utf8dv_pkg::*;
(
	input  logic                cont,
	input  logic [7:0]          byte_in,
	input  logic [CP_WIDTH-1:0] cp_in,
	output step_res_t           res
);

	always_comb begin
		res = '0;
		if (cont) begin
			res.len = 3'd1;
			res.bad = (byte_in & MASK_CONT) != CODE_CONT;
			res.cp  = {cp_in[CP_WIDTH-7:0], byte_in[5:0] & BITS_CONT[5:0]};
		end else if (byte_in < ASCII_LIMIT) begin
			res.len = 3'd1;
			res.cp  = CP_WIDTH'(byte_in);
		end else if ((byte_in & MASK_LEAD2) == CODE_LEAD2) begin
			res.len = 3'd2;
			res.cp  = CP_WIDTH'(byte_in & BITS_LEAD2);
		end else if ((byte_in & MASK_LEAD3) == CODE_LEAD3) begin
			res.len = 3'd3;
			res.cp  = CP_WIDTH'(byte_in & BITS_LEAD3);
		end else if ((byte_in & MASK_LEAD4) == CODE_LEAD4) begin
			res.len = 3'd4;
			res.cp  = CP_WIDTH'(byte_in & BITS_LEAD4);
		end else begin
			res.bad = 1'b1;
			res.len = 3'd1;
		end
	end

endmodule

[design/utf8_decode_validate_unit.sv]
// ----------------------------------------------------------------------------
// utf8_decode_validate_unit
// Streaming UTF-8 decoder with validity tracking and end-of-string summary.
// ----------------------------------------------------------------------------
// Takes one byte word at a time and returns one word per decoded code point,
// plus a summary word when the input word ends the string; the final word
// caused by an input has last_result set. Up to three bytes of an unfinished
// sequence stay in a four-entry shift queue between input words. A small
// sequencer runs the queue through one shared byte unit, one byte per cycle
// while the result side does not stall. Its steps, in order: accept the
// word, examine each byte, find the queue empty or short, emit each code
// point, then settle held bytes (and the summary) and hand over the last
// word. Emitting waits while the result side stalls.
// The input is stalled until the sequence of steps for the current word ends.
// ----------------------------------------------------------------------------
module utf8_decode_validate_unit
	import utf8dv_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  logic    item_valid,
	output logic    item_stall,
	output result_t result,
	output logic    result_valid,
	input  logic    result_stall
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEAD,
		ST_CONT,
		ST_EMIT,
		ST_FIN,
		ST_FLUSH
	} state_t;

	state_t                 state_q;
	logic [7:0]             q_q [4];
	logic [2:0]             cnt_q;
	logic [1:0]             rem_q;
	logic [CP_WIDTH-1:0]    cp_q;
	logic                   brk_q;
	logic                   valid_q;
	logic                   eos_q;
	logic [COUNT_WIDTH-1:0] ctr_q;
	result_t                pend_q;
	logic                   pend_valid_q;
	result_t                out_q;
	logic                   out_valid_q;

	step_res_t              step;
	logic [COUNT_WIDTH-1:0] ctr_inc;
	logic [TOTAL_WIDTH-1:0] tot_cur;
	logic [TOTAL_WIDTH-1:0] tot_inc;
	logic                   out_free;
	logic                   can_move;
	logic                   push;
	logic                   push_last;

	utf8dv_step u_step (
		.cont    (state_q == ST_CONT),
		.byte_in (q_q[0]),
		.cp_in   (cp_q),
		.res     (step)
	);

	assign ctr_inc = (ctr_q == '1) ? ctr_q : ctr_q + COUNT_WIDTH'(1);

	generate
		if (COUNT_WIDTH > TOTAL_WIDTH) begin : g_sat
			assign tot_cur = (ctr_q > COUNT_WIDTH'({TOTAL_WIDTH{1'b1}})) ?
				'1 : ctr_q[TOTAL_WIDTH-1:0];
			assign tot_inc = (ctr_inc > COUNT_WIDTH'({TOTAL_WIDTH{1'b1}})) ?
				'1 : ctr_inc[TOTAL_WIDTH-1:0];
		end else begin : g_ext
			assign tot_cur = TOTAL_WIDTH'(ctr_q);
			assign tot_inc = TOTAL_WIDTH'(ctr_inc);
		end
	endgenerate

	assign out_free = !out_valid_q || !result_stall;
	assign can_move = !pend_valid_q || out_free;

	always_comb begin
		push      = 1'b0;
		push_last = 1'b0;
		unique case (state_q)
			ST_EMIT:  push = pend_valid_q && out_free;
			ST_FIN:   push = eos_q && pend_valid_q && out_free;
			ST_FLUSH: begin
				push      = pend_valid_q && out_free;
				push_last = 1'b1;
			end
			default: begin
				push      = 1'b0;
				push_last = 1'b0;
			end
		endcase
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign result       = out_q;
	assign result_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			rem_q        <= '0;
			brk_q        <= 1'b0;
			valid_q      <= 1'b1;
			eos_q        <= 1'b0;
			ctr_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (push) begin
				out_valid_q <= 1'b1;
				out_q       <= {pend_q[$bits(result_t)-1:1], push_last};
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						if (item.byte_present) begin
							q_q[cnt_q[1:0]] <= item.data_byte;
						end
						cnt_q   <= cnt_q + 3'(item.byte_present);
						eos_q   <= item.end_of_string;
						brk_q   <= 1'b0;
						state_q <= ST_LEAD;
					end
				end
				ST_LEAD: begin
					if (cnt_q == '0) begin
						state_q <= ST_FIN;
					end else if (step.bad) begin
						valid_q <= 1'b0;
						q_q[0]  <= q_q[1];
						q_q[1]  <= q_q[2];
						q_q[2]  <= q_q[3];
						cnt_q   <= cnt_q - 3'd1;
					end else if (step.len > cnt_q) begin
						state_q <= ST_FIN;
					end else begin
						cp_q   <= step.cp;
						q_q[0] <= q_q[1];
						q_q[1] <= q_q[2];
						q_q[2] <= q_q[3];
						cnt_q  <= cnt_q - 3'd1;
						rem_q  <= 2'(step.len - 3'd1);
						state_q <= (step.len == 3'd1) ? ST_EMIT : ST_CONT;
					end
				end
				ST_CONT: begin
					if (step.bad) begin
						valid_q <= 1'b0;
						brk_q   <= 1'b1;
						state_q <= ST_EMIT;
					end else begin
						cp_q   <= step.cp;
						q_q[0] <= q_q[1];
						q_q[1] <= q_q[2];
						q_q[2] <= q_q[3];
						cnt_q  <= cnt_q - 3'd1;
						rem_q  <= rem_q - 2'd1;
						if (rem_q == 2'd1) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (can_move) begin
						pend_q.kind        <= KIND_POINT;
						pend_q.code_point  <= cp_q;
						pend_q.broken      <= brk_q;
						pend_q.point_total <= tot_inc;
						pend_q.all_valid   <= valid_q;
						pend_q.last_result <= 1'b0;
						pend_valid_q       <= 1'b1;
						ctr_q              <= ctr_inc;
						brk_q              <= 1'b0;
						state_q            <= ST_LEAD;
					end
				end
				ST_FIN: begin
					if (!eos_q) begin
						state_q <= ST_FLUSH;
					end else if (can_move) begin
						pend_q.kind        <= KIND_SUMMARY;
						pend_q.code_point  <= '0;
						pend_q.broken      <= 1'b0;
						pend_q.point_total <= tot_cur;
						pend_q.all_valid   <= valid_q && (cnt_q == '0);
						pend_q.last_result <= 1'b0;
						pend_valid_q       <= 1'b1;
						cnt_q              <= '0;
						ctr_q              <= '0;
						valid_q            <= 1'b1;
						state_q            <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[verif/utf8_decode_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_decode_checker
// Watches both channels of the UTF-8 decode unit and checks every result word.
// ----------------------------------------------------------------------------
// Each accepted input word runs through a local decoder that keeps its own
// held bytes, point count and valid flag. The words it predicts queue up in
// order and each accepted result word is compared field by field with the
// oldest one. The mismatch count and the number of words still awaited go
// back to the testbench top.
// ----------------------------------------------------------------------------
module utf8_decode_checker
	import utf8dv_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  logic    item_valid,
	input  logic    item_stall,
	input  result_t result,
	input  logic    result_valid,
	input  logic    result_stall,
	output int      mismatches,
	output int      pending
);

	logic [7:0]             held [0:2];
	int                     held_n;
	logic [TOTAL_WIDTH-1:0] points;
	logic                   clean;
	result_t                awaited_words [$];
	result_t                want;

	function automatic result_t point_word(logic kind, logic [CP_WIDTH-1:0] cp, logic brk);
		result_t w;
		w.kind        = kind;
		w.code_point  = cp;
		w.broken      = brk;
		w.point_total = points;
		w.all_valid   = clean;
		w.last_result = 1'b0;
		return w;
	endfunction

	function automatic void decode_word(item_t it);
		logic [7:0]          q [0:3];
		result_t             batch [0:4];
		logic [7:0]          lead;
		logic [7:0]          part;
		logic [CP_WIDTH-1:0] cp;
		logic                brk;
		int                  n;
		int                  pos;
		int                  len;
		int                  used;
		int                  nres;
		int                  i;
		n    = held_n;
		pos  = 0;
		nres = 0;
		for (i = 0; i < n; i++)
			q[i] = held[i];
		if (it.byte_present) begin
			q[n] = it.data_byte;
			n++;
		end
		while (pos < n) begin
			lead = q[pos];
			brk  = 1'b0;
			if (lead < ASCII_LIMIT) begin
				cp  = CP_WIDTH'(lead);
				len = 1;
			end else if ((lead & MASK_LEAD2) == CODE_LEAD2) begin
				cp  = CP_WIDTH'(lead & BITS_LEAD2);
				len = 2;
			end else if ((lead & MASK_LEAD3) == CODE_LEAD3) begin
				cp  = CP_WIDTH'(lead & BITS_LEAD3);
				len = 3;
			end else if ((lead & MASK_LEAD4) == CODE_LEAD4) begin
				cp  = CP_WIDTH'(lead & BITS_LEAD4);
				len = 4;
			end else begin
				clean = 1'b0;
				pos++;
				continue;
			end
			if (pos + len > n)
				break;
			used = len;
			for (i = 1; i < len; i++) begin
				part = q[pos + i];
				if ((part & MASK_CONT) != CODE_CONT) begin
					clean = 1'b0;
					used  = i;
					brk   = 1'b1;
					break;
				end
				cp = (cp << 6) | CP_WIDTH'(part & BITS_CONT);
			end
			if (points != '1)
				points++;
			batch[nres] = point_word(KIND_POINT, cp, brk);
			nres++;
			pos += used;
		end
		held_n = n - pos;
		for (i = 0; i < held_n; i++)
			held[i] = q[pos + i];
		if (it.end_of_string) begin
			// unfinished sequence at end of string is dropped as an error
			if (held_n != 0)
				clean = 1'b0;
			batch[nres] = point_word(KIND_SUMMARY, '0, 1'b0);
			nres++;
			held_n = 0;
			points = '0;
			clean  = 1'b1;
		end
		if (nres > 0)
			batch[nres - 1].last_result = 1'b1;
		for (i = 0; i < nres; i++)
			awaited_words = {awaited_words, batch[i]};
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		$display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, exp_val);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			held_n     = 0;
			points     = '0;
			clean      = 1'b1;
			mismatches = 0;
			awaited_words.delete();
			pending    <= 0;
		end else begin
			if (item_valid && !item_stall)
				decode_word(item);
			if (result_valid && !result_stall) begin
				if (awaited_words.size() == 0) begin
					report_mismatch("unexpected word", 32'(result.code_point), '0);
				end else begin
					want = awaited_words.pop_front();
					if (result.kind !== want.kind)
						report_mismatch("kind", 32'(result.kind), 32'(want.kind));
					if (result.code_point !== want.code_point)
						report_mismatch("code_point", 32'(result.code_point),
							32'(want.code_point));
					if (result.broken !== want.broken)
						report_mismatch("broken", 32'(result.broken), 32'(want.broken));
					if (result.point_total !== want.point_total)
						report_mismatch("point_total", result.point_total, want.point_total);
					if (result.all_valid !== want.all_valid)
						report_mismatch("all_valid", 32'(result.all_valid),
							32'(want.all_valid));
					if (result.last_result !== want.last_result)
						report_mismatch("last_result", 32'(result.last_result),
							32'(want.last_result));
				end
			end
			pending <= awaited_words.size();
		end
	end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the UTF-8 decode and validate unit.
// ----------------------------------------------------------------------------
// A directed opening covers ASCII extremes, every sequence length up to the
// largest code point, bad leads, cut-short sequences, unfinished strings at
// end, absent bytes and end-only words. The random part is mostly well-formed
// sequences with random payload bits, mixed with noise bytes and broken
// sequences. Both sides idle at random; the checker does all comparing.
// ----------------------------------------------------------------------------
module testbench;
	import utf8dv_pkg::*;

	localparam int RANDOM_WORDS = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 500000;

	logic    clk;
	logic    arst_n;
	item_t   item;
	logic    item_valid;
	logic    item_stall;
	result_t result;
	logic    result_valid;
	logic    result_stall;

	int      mismatches;
	int      pending;
	int      cycles;
	int      sent;
	int      stall_left;
	int      stall_draw;
	bit      quiet;

	utf8_decode_validate_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

	utf8_decode_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result side: after each accepted word, draw a random stall before the next one (none while quiet)
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left   <= 0;
		end else if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else if (stall_left == 1) begin
			stall_left   <= 0;
			result_stall <= 1'b0;
		end else if (result_valid && !result_stall) begin
			stall_draw = quiet ? 0 : $urandom_range(0, 16);
			stall_left   <= stall_draw;
			result_stall <= (stall_draw > 0);
		end
	end

	task automatic send_word(input logic [7:0] b, input logic present, input logic done);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item       <= '{data_byte: b, byte_present: present, end_of_string: done};
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sent++;
	endtask

	// one sequence of len bytes, or, if cut is below len, only up to the byte at offset cut, which is random
	task automatic send_sequence(input int len, input int cut);
		logic [7:0] b;
		int         k;
		for (k = 0; k < len; k++) begin
			if (k == cut)
				b = 8'($urandom_range(0, 255));
			else if (k > 0)
				b = CODE_CONT | (8'($urandom) & BITS_CONT);
			else if (len == 1)
				b = 8'($urandom) & (ASCII_LIMIT - 8'd1);
			else if (len == 2)
				b = CODE_LEAD2 | (8'($urandom) & BITS_LEAD2);
			else if (len == 3)
				b = CODE_LEAD3 | (8'($urandom) & BITS_LEAD3);
			else
				b = CODE_LEAD4 | (8'($urandom) & BITS_LEAD4);
			send_word(b, 1'b1, $urandom_range(0, 24) == 0);
			if (k == cut)
				break;
		end
	endtask

	initial begin
		int sel;
		int len;
		arst_n       = 1'b0;
		item         = '0;
		item_valid   = 1'b0;
		sent         = 0;
		quiet        = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(8'h00, 1'b1, 1'b0);
		send_word(8'h7F, 1'b1, 1'b0);
		send_word(8'hC2, 1'b1, 1'b0);
		send_word(8'hA9, 1'b1, 1'b0);
		send_word(8'hE2, 1'b1, 1'b0);
		send_word(8'h82, 1'b1, 1'b0);
		send_word(8'hAC, 1'b1, 1'b0);
		send_word(8'hF7, 1'b1, 1'b0);
		send_word(8'hBF, 1'b1, 1'b0);
		send_word(8'hBF, 1'b1, 1'b0);
		send_word(8'hBF, 1'b1, 1'b0);
		// bad leads
		send_word(8'h80, 1'b1, 1'b0);
		send_word(8'hFF, 1'b1, 1'b0);
		send_word(8'hF8, 1'b1, 1'b0);
		// broken at first continuation, three bytes replayed, then end
		send_word(8'hF0, 1'b1, 1'b0);
		send_word(8'h41, 1'b1, 1'b0);
		send_word(8'h42, 1'b1, 1'b0);
		send_word(8'h43, 1'b1, 1'b1);
		// broken at last continuation
		send_word(8'hF0, 1'b1, 1'b0);
		send_word(8'h9F, 1'b1, 1'b0);
		send_word(8'h98, 1'b1, 1'b0);
		send_word(8'h41, 1'b1, 1'b0);
		// unfinished at end
		send_word(8'hC3, 1'b1, 1'b1);
		send_word(8'hFF, 1'b0, 1'b0);
		send_word(8'h00, 1'b0, 1'b1);

		sent = 0;
		while (sent < RANDOM_WORDS) begin
			if ($urandom_range(0, 15) == 0)
				quiet = ($urandom_range(0, 2) == 0);
			sel = $urandom_range(0, 19);
			len = $urandom_range(1, 4);
			if (sel < 15)
				send_sequence(len, len);
			else if (sel == 15)
				send_sequence(len, $urandom_range(1, 4) - 1);
			else if (sel == 16)
				send_word(8'($urandom_range(0, 255)), 1'b1, $urandom_range(0, 24) == 0);
			else if (sel == 17)
				send_word($urandom_range(0, 1) ? (CODE_CONT | (8'($urandom) & BITS_CONT))
					: (MASK_LEAD4 | (8'($urandom) & BITS_LEAD4)), 1'b1, 1'b0);
			else if (sel == 18)
				send_word(8'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 3) == 0);
			else
				send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		end
		item_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[filelist.f]
design/utf8dv_pkg.sv
design/utf8dv_step.sv
design/utf8_decode_validate_unit.sv
verif/utf8_decode_checker.sv
verif/testbench.sv
